/* src/bkms_pkg.sv */
package bkms_pkg;

    localparam int HASH_W = 64;
    localparam int CFG_W  = 7;

    localparam logic [HASH_W-1:0] ALL_ONES       = {HASH_W{1'b1}};
    localparam logic [HASH_W-1:0] ZERO_DIV_SUBST = HASH_W'(1000000);

    // one quotient bit per divider step
    localparam int DIV_STEPS = HASH_W;
    localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

    // controller -> datapath
    typedef struct packed {
        logic cfg_wr;    // sketch_size write, empties the sketch
        logic load;      // latch the input item
        logic scan;      // issue the next slot read
        logic decide;    // insert decision and slot write
        logic div_init;  // load the divider
        logic div_step;  // one restoring division step
        logic mul;       // scale quotient by k
        logic out_load;  // move the result into the output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic div_done;
    } t_dp_sts;

endpackage

/* src/bkms_datapath.sv */
module bkms_datapath #(
    parameter int SKETCH_DEPTH = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bkms_pkg::t_dp_cmd                  i_cmd,
    output bkms_pkg::t_dp_sts                  o_sts,
    input  logic [bkms_pkg::CFG_W-1:0]         i_cfg_sketch_size,
    input  logic [bkms_pkg::HASH_W-1:0]        i_kmer_hash,
    input  logic                               i_start_new,
    output logic                               o_accepted,
    output logic [bkms_pkg::HASH_W-1:0]        o_kth_smallest,
    output logic [bkms_pkg::HASH_W-1:0]        o_estimate
);

    localparam int KW    = $clog2(SKETCH_DEPTH + 1);
    localparam int AW    = (SKETCH_DEPTH > 1) ? $clog2(SKETCH_DEPTH) : 1;
    localparam int K_RST = (SKETCH_DEPTH < 64) ? SKETCH_DEPTH : 64;
    localparam int HW    = bkms_pkg::HASH_W;

    logic [HW-1:0]   r_mem [SKETCH_DEPTH];

    // control state
    logic [KW-1:0]   r_k;
    logic [KW-1:0]   r_fill;
    logic            r_rd_vld;
    logic [bkms_pkg::DIV_CW-1:0] r_div_cnt;

    // payload
    logic [HW-1:0]   r_hash;
    logic [KW-1:0]   r_addr;
    logic [HW-1:0]   r_rd_data;
    logic            r_rd_virt;
    logic [AW-1:0]   r_rd_idx;
    logic [HW-1:0]   r_max1;
    logic [HW-1:0]   r_max2;
    logic [AW-1:0]   r_idx;
    logic            r_seen;
    logic            r_acc;
    logic [HW-1:0]   r_kth;
    logic [HW-1:0]   r_dvs;
    logic [HW:0]     r_rem;
    logic [HW-1:0]   r_quo;
    logic [HW-1:0]   r_est;
    logic            r_out_acc;
    logic [HW-1:0]   r_out_kth;
    logic [HW-1:0]   r_out_est;

    logic [31:0]     n_k_wide;
    logic [KW-1:0]   n_k;
    logic            issue;
    logic [HW-1:0]   rd_val;
    logic            n_acc;
    logic [HW-1:0]   n_kth;
    logic [HW:0]     rem_sh;
    logic            rem_ge;
    logic [HW+KW-1:0] prod;

    // clamp the register value to 1..SKETCH_DEPTH
    always_comb begin
        n_k_wide = 32'(i_cfg_sketch_size);
        if (n_k_wide == 32'd0) begin
            n_k_wide = 32'd1;
        end
        if (n_k_wide > 32'(SKETCH_DEPTH)) begin
            n_k_wide = 32'(SKETCH_DEPTH);
        end
        n_k = KW'(n_k_wide);
    end

    assign issue  = i_cmd.scan && (r_addr != r_k);
    assign rd_val = r_rd_virt ? bkms_pkg::ALL_ONES : r_rd_data;

    // insert when below the largest held value and not a duplicate
    assign n_acc = (r_hash < r_max1) && !r_seen;

    always_comb begin
        if (!n_acc) begin
            n_kth = r_max1;
        end else if (r_hash > r_max2) begin
            n_kth = r_hash;
        end else begin
            n_kth = r_max2;
        end
    end

    assign rem_sh = {r_rem[HW-1:0], r_quo[HW-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_dvs});
    assign prod   = r_quo * r_k;

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide && n_acc) begin
            r_mem[r_idx] <= r_hash;
        end
        if (issue) begin
            r_rd_data <= r_mem[r_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k       <= KW'(K_RST);
            r_fill    <= '0;
            r_rd_vld  <= 1'b0;
            r_div_cnt <= '0;
        end else begin
            if (i_cmd.cfg_wr) begin
                r_k    <= n_k;
                r_fill <= '0;
            end else if (i_cmd.load && i_start_new) begin
                r_fill <= '0;
            end else if (i_cmd.decide && n_acc && (r_max1 == bkms_pkg::ALL_ONES)) begin
                // an empty slot was taken; it is always the next one in order
                r_fill <= r_fill + KW'(1);
            end
            r_rd_vld <= issue;
            if (i_cmd.div_init) begin
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + bkms_pkg::DIV_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hash <= i_kmer_hash;
            r_addr <= '0;
            r_max1 <= '0;
            r_max2 <= '0;
            r_idx  <= '0;
            r_seen <= 1'b0;
        end else begin
            if (issue) begin
                r_addr    <= r_addr + KW'(1);
                r_rd_idx  <= r_addr[AW-1:0];
                r_rd_virt <= (r_addr >= r_fill);
            end
            // running top-two over the active slots, first index wins ties
            if (r_rd_vld) begin
                if (rd_val > r_max1) begin
                    r_max2 <= r_max1;
                    r_max1 <= rd_val;
                    r_idx  <= r_rd_idx;
                end else if (rd_val > r_max2) begin
                    r_max2 <= rd_val;
                end
                if (rd_val == r_hash) begin
                    r_seen <= 1'b1;
                end
            end
        end

        if (i_cmd.decide) begin
            r_acc <= n_acc;
            r_kth <= n_kth;
        end

        if (i_cmd.div_init) begin
            r_dvs <= (r_kth == '0) ? bkms_pkg::ZERO_DIV_SUBST : r_kth;
            r_rem <= '0;
            r_quo <= bkms_pkg::ALL_ONES;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
            r_quo <= {r_quo[HW-2:0], rem_ge};
        end

        if (i_cmd.mul) begin
            r_est <= prod[HW-1:0];
        end

        if (i_cmd.out_load) begin
            r_out_acc <= r_acc;
            r_out_kth <= r_kth;
            r_out_est <= r_est;
        end
    end

    assign o_sts.scan_done = (r_addr == r_k) && !r_rd_vld;
    assign o_sts.div_done  = (r_div_cnt == bkms_pkg::DIV_CW'(bkms_pkg::DIV_STEPS));

    assign o_accepted     = r_out_acc;
    assign o_kth_smallest = r_out_kth;
    assign o_estimate     = r_out_est;

`ifndef SYNTHESIS
    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_k)
        else $error("fill count beyond active slots");

    a_empty_slot_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.decide && n_acc && (r_max1 == bkms_pkg::ALL_ONES))
            |-> (r_idx == r_fill[AW-1:0]))
        else $error("empty slot taken out of order");

    a_rem_below_dvs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < {1'b0, r_dvs}))
        else $error("divider remainder not below divisor");
`endif

endmodule

/* src/bkms_ctrl.sv */
module bkms_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    output bkms_pkg::t_dp_cmd  o_cmd,
    input  bkms_pkg::t_dp_sts  i_sts
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_PREP   = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_MUL    = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.cfg_wr = i_cfg_valid;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_PREP;
            end
            S_PREP: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_MUL;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before transfer");

    a_div_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV) && i_sts.div_done) |=> (r_state == S_MUL))
        else $error("divider finish not followed by scaling");

    a_scan_to_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && i_sts.scan_done) |=> (r_state == S_DECIDE))
        else $error("scan finish not followed by decision");
`endif

endmodule

/* src/bottom_k_minhash_sketch.sv */
// Bottom-k MinHash sketch. Keeps the k smallest distinct 64-bit hashes seen
// (k = sketch_size, clamped to 1..SKETCH_DEPTH; 0 acts as 1). Empty slots read as
// all-ones. Per input transfer: start_new empties the sketch first; the hash
// then replaces the largest held value if it is smaller and not already held.
// Every input yields exactly one result: accepted, the largest held value
// (kth_smallest), and estimate = (all-ones / kth_smallest) * k, wrapping to
// 64 bits, with a zero divisor replaced by 1000000. Writing sketch_size also
// empties the sketch; write it only while the block is idle.
// Sequence: one read-and-compare pass over the k active slots through the
// single read port of the slot memory, the insert decision, a restoring
// divider producing one quotient bit a cycle (a load, 64 steps and a
// finish), the scaling by k and the fill of the output register. One item
// is in flight at a time, so an input transfer is taken only once the last
// result has reached the output register; the finished result sits in an
// output register, so the next input transfer is taken while it waits to be
// read.
// No clearing pass after reset: a fill count marks which slots are occupied.
module bottom_k_minhash_sketch #(
    parameter int SKETCH_DEPTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input items
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [bkms_pkg::HASH_W-1:0]    i_kmer_hash,
    input  logic                           i_start_new,
    // results
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_accepted,
    output logic [bkms_pkg::HASH_W-1:0]    o_kth_smallest,
    output logic [bkms_pkg::HASH_W-1:0]    o_estimate,
    // sketch_size register write
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bkms_pkg::CFG_W-1:0]     i_cfg_sketch_size
);

    bkms_pkg::t_dp_cmd cmd;
    bkms_pkg::t_dp_sts sts;

    // sequencing and the input, output and register-write handshakes
    bkms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // slot memory, scan, divider and result register
    bkms_datapath #(
        .SKETCH_DEPTH (SKETCH_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_sketch_size (i_cfg_sketch_size),
        .i_kmer_hash       (i_kmer_hash),
        .i_start_new       (i_start_new),
        .o_accepted        (o_accepted),
        .o_kth_smallest    (o_kth_smallest),
        .o_estimate        (o_estimate)
    );

endmodule

/* bench/bottom_k_minhash_sketch_chk.sv */
`timescale 1ns / 1ps
module bottom_k_minhash_sketch_chk #(
    parameter int SKETCH_DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [bkms_pkg::HASH_W-1:0] i_kmer_hash,
    input  logic                        i_start_new,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic                        i_accepted,
    input  logic [bkms_pkg::HASH_W-1:0] i_kth_smallest,
    input  logic [bkms_pkg::HASH_W-1:0] i_estimate,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [bkms_pkg::CFG_W-1:0]  i_cfg_sketch_size,
    output int                          o_pending,
    output int                          o_fail_count
);

    typedef struct packed {
        logic                        accepted;
        logic [bkms_pkg::HASH_W-1:0] kth;
        logic [bkms_pkg::HASH_W-1:0] estimate;
    } t_sketch_result;

    logic [bkms_pkg::HASH_W-1:0] slots [SKETCH_DEPTH];
    logic [bkms_pkg::CFG_W-1:0]  size_reg;
    t_sketch_result              pending_results [$];
    int                          n_fail = 0;

    function automatic void empty_sketch();
        for (int i = 0; i < SKETCH_DEPTH; i++)
            slots[i] = bkms_pkg::ALL_ONES;
    endfunction

    // 0 acts as 1, anything past the depth acts as the depth
    function automatic int active_k();
        if (size_reg == '0)
            return 1;
        if (int'(size_reg) > SKETCH_DEPTH)
            return SKETCH_DEPTH;
        return int'(size_reg);
    endfunction

    function automatic int largest_slot(input int k);
        int top = 0;
        for (int i = 1; i < k; i++)
            if (slots[i] > slots[top])
                top = i;
        return top;
    endfunction

    function automatic t_sketch_result sketch_insert(
        input logic [bkms_pkg::HASH_W-1:0] h,
        input logic                        fresh);
        t_sketch_result              r;
        int                          k;
        int                          top;
        logic                        held;
        logic [bkms_pkg::HASH_W-1:0] divisor;
        k          = active_k();
        held       = 1'b0;
        r.accepted = 1'b0;
        if (fresh)
            empty_sketch();
        top = largest_slot(k);
        if (h < slots[top]) begin
            for (int i = 0; i < k; i++)
                if (slots[i] == h)
                    held = 1'b1;
            if (!held) begin
                slots[top] = h;
                r.accepted = 1'b1;
            end
        end
        r.kth      = slots[largest_slot(k)];
        divisor    = (r.kth == '0) ? bkms_pkg::ZERO_DIV_SUBST : r.kth;
        r.estimate = (bkms_pkg::ALL_ONES / divisor) * bkms_pkg::HASH_W'(k);
        return r;
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [bkms_pkg::HASH_W-1:0] got,
                                   input logic [bkms_pkg::HASH_W-1:0] want);
        $display("%0t: sketch result %s: got %h, want %h", $time, what, got, want);
        n_fail++;
    endtask

    always @(posedge i_clk) begin
        t_sketch_result want;
        if (!i_rst_n) begin
            empty_sketch();
            size_reg = bkms_pkg::CFG_W'(64);
            pending_results.delete();
        end else begin
            // compare before pushing: a result never leaves in its own input's cycle
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("with none outstanding", i_kth_smallest, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_accepted !== want.accepted)
                        report_mismatch("accepted", bkms_pkg::HASH_W'(i_accepted),
                                        bkms_pkg::HASH_W'(want.accepted));
                    if (i_kth_smallest !== want.kth)
                        report_mismatch("kth_smallest", i_kth_smallest, want.kth);
                    if (i_estimate !== want.estimate)
                        report_mismatch("estimate", i_estimate, want.estimate);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                size_reg = i_cfg_sketch_size;
                empty_sketch();
            end
            if (i_in_valid && i_in_ready)
                pending_results.insert(pending_results.size(),
                                       sketch_insert(i_kmer_hash, i_start_new));
        end
        o_pending    <= pending_results.size();
        o_fail_count <= n_fail;
    end

endmodule

/* bench/bottom_k_minhash_sketch_tb.sv */
`timescale 1ns / 1ps
module bottom_k_minhash_sketch_tb;

    localparam int SKETCH_DEPTH = 64;
    localparam int RESET_CYCLES = 11;
    localparam int N_PHASES     = 10;
    localparam int PHASE_ITEMS  = 175;
    // quiet time at the end, a few items' worth
    localparam int DRAIN_CYCLES = 400;
    // slowest per-item time over ~1750 items, taken several times over
    localparam int CYCLE_LIMIT  = 1_500_000;
    // long receiver stall: starts after this many input transfers
    localparam int HOLD_AFTER   = 40;
    localparam int HOLD_CYCLES  = 1500;

    // receiver behavior, switched after a random stretch
    typedef enum logic [1:0] {
        RX_STREAM,  // always ready
        RX_COIN,    // ready half the time
        RX_SPARSE   // ready one cycle in eight
    } t_rx_mode;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        in_valid     = 1'b0;
    logic                        in_ready;
    logic [bkms_pkg::HASH_W-1:0] kmer_hash    = '0;
    logic                        start_new    = 1'b0;
    logic                        out_valid;
    logic                        out_ready    = 1'b0;
    logic                        accepted;
    logic [bkms_pkg::HASH_W-1:0] kth_smallest;
    logic [bkms_pkg::HASH_W-1:0] estimate;
    logic                        cfg_valid    = 1'b0;
    logic                        cfg_ready;
    logic [bkms_pkg::CFG_W-1:0]  cfg_size     = '0;

    int pending;
    int fail_count;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    bottom_k_minhash_sketch #(
        .SKETCH_DEPTH (SKETCH_DEPTH)
    ) u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_kmer_hash       (kmer_hash),
        .i_start_new       (start_new),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_accepted        (accepted),
        .o_kth_smallest    (kth_smallest),
        .o_estimate        (estimate),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_sketch_size (cfg_size)
    );

    bottom_k_minhash_sketch_chk #(
        .SKETCH_DEPTH (SKETCH_DEPTH)
    ) u_chk (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_kmer_hash       (kmer_hash),
        .i_start_new       (start_new),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_accepted        (accepted),
        .i_kth_smallest    (kth_smallest),
        .i_estimate        (estimate),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_sketch_size (cfg_size),
        .o_pending         (pending),
        .o_fail_count      (fail_count)
    );

    // Watchdog: a hung handshake ends the run here.
    int cycles = 0;
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("bottom_k_minhash_sketch_tb NOT OK");
            $finish;
        end
    end

    // Receiver. Picks a stall mode for a random stretch, then another one.
    // Once, after HOLD_AFTER input transfers, it holds ready low for a long
    // stretch: the result register fills, the next item finishes behind it,
    // and the block has to push back on its input while the sender keeps on.
    t_rx_mode rx_mode     = RX_STREAM;
    int       rx_left     = 0;
    int       hold_left   = 0;
    logic     hold_done   = 1'b0;
    int       in_xfers    = 0;

    always @(posedge clk) begin
        if (in_valid && in_ready)
            in_xfers++;
        if (!hold_done && in_xfers == HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 2));
                rx_left = $urandom_range(20, 300);
            end
            rx_left--;
            case (rx_mode)
                RX_STREAM: out_ready <= 1'b1;
                RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                default:   out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Sender state: items left in the current burst, and recent hashes
    // kept around so duplicates show up at a useful rate.
    int                          burst_left = 0;
    logic [bkms_pkg::HASH_W-1:0] recent [$];

    // One input transfer. At a burst boundary valid drops for a random gap;
    // a quarter of the bursts follow with no gap at all. Inside a burst
    // valid stays high and only the payload changes.
    task automatic send_hash(input logic [bkms_pkg::HASH_W-1:0] h, input logic fresh);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid   <= 1'b1;
        kmer_hash  <= h;
        start_new  <= fresh;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        if (recent.size() == 16)
            recent.delete(0);
        recent.insert(recent.size(), h);
    endtask

    // Register write, only with nothing in flight. The write also empties
    // the sketch, which the checker mirrors on the same transfer.
    task automatic set_size(input logic [bkms_pkg::CFG_W-1:0] k);
        in_valid   <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
        cfg_valid <= 1'b1;
        cfg_size  <= k;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Hash mix: full-width random values exercise every bit; small values
    // hit zero and collide; repeats of recent hashes test the duplicate
    // check; values at and just under all-ones sit next to the sentinel; shifted
    // values land below a filled sketch's largest so late inserts still happen.
    function automatic logic [bkms_pkg::HASH_W-1:0] pick_hash();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            return {$urandom, $urandom};
        if (roll < 55)
            return bkms_pkg::HASH_W'($urandom_range(0, 255));
        if (roll < 70 && recent.size() > 0)
            return recent[$urandom_range(0, recent.size() - 1)];
        if (roll < 80)
            return bkms_pkg::ALL_ONES - bkms_pkg::HASH_W'($urandom_range(0, 3));
        return {$urandom, $urandom} >> $urandom_range(1, 60);
    endfunction

    // Register settings for the random phases: both ends of the legal
    // range, zero and the all-ones code (out of range), plus two drawn ones.
    logic [bkms_pkg::CFG_W-1:0] phase_size [N_PHASES] = '{
        7'd2, 7'd64, 7'd1, 7'd3, 7'd8, 7'd0, 7'd127, 7'd16, 7'd5, 7'd100
    };

    initial begin
        phase_size[8] = bkms_pkg::CFG_W'($urandom_range(4, 63));
        phase_size[9] = bkms_pkg::CFG_W'($urandom_range(65, 126));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, at the reset size of 64. Sentinel hash with start_new
        // is never taken; zero goes in, then again as a duplicate; values
        // either side of the top bit and just under all-ones.
        send_hash(bkms_pkg::ALL_ONES, 1'b1);
        send_hash(64'd0, 1'b0);
        send_hash(64'd0, 1'b0);
        send_hash(64'd1, 1'b0);
        send_hash(bkms_pkg::ALL_ONES - 64'd1, 1'b0);
        send_hash(64'h8000_0000_0000_0000, 1'b0);
        send_hash(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        send_hash(64'd5, 1'b1);

        // k = 1: a held zero makes the divisor zero, so the substitute applies.
        set_size(7'd1);
        send_hash(64'd0, 1'b0);
        send_hash(64'd0, 1'b0);
        send_hash(bkms_pkg::ALL_ONES, 1'b0);
        send_hash(64'd3, 1'b1);
        send_hash(64'd2, 1'b0);
        send_hash(64'd2, 1'b0);

        // size zero behaves as one; the write itself emptied the sketch
        set_size(7'd0);
        send_hash(bkms_pkg::ALL_ONES - 64'd1, 1'b0);
        send_hash(64'd0, 1'b0);
        send_hash(64'd0, 1'b0);

        // above the depth: clamps to 64 slots, estimate scaled by 64
        set_size(7'd127);
        send_hash(64'd10, 1'b0);
        send_hash(64'd9, 1'b0);
        send_hash(bkms_pkg::ALL_ONES, 1'b1);

        // Random phases. start_new lands now and then so the sketch keeps
        // refilling from empty; each phase opens with a coin toss on it.
        for (int p = 0; p < N_PHASES; p++) begin
            set_size(phase_size[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_hash(pick_hash(),
                          (n == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 29) == 0));
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        // quiet period: any extra result from here on is flagged by the checker
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("bottom_k_minhash_sketch_tb OK");
        else
            $display("bottom_k_minhash_sketch_tb NOT OK");
        $finish;
    end

endmodule
